/* rtl/core/appt_pkg.sv */
// Shared codes and beat types for the ATAPI packet phase tracker.
`timescale 1ns / 1ps

package appt_pkg;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_IRQ   = 1'b1;

    // Phase codes reported on the result channel
    localparam logic [2:0] PHASE_IDLE    = 3'd0;
    localparam logic [2:0] PHASE_RELEASE = 3'd1;
    localparam logic [2:0] PHASE_COMMAND = 3'd2;
    localparam logic [2:0] PHASE_STATUS  = 3'd3;
    localparam logic [2:0] PHASE_MESSAGE = 3'd4;
    localparam logic [2:0] PHASE_H2D     = 3'd5;
    localparam logic [2:0] PHASE_D2H     = 3'd6;

    // Anomaly codes
    localparam logic [2:0] ANOM_NONE    = 3'd0;
    localparam logic [2:0] ANOM_BUSY    = 3'd1;
    localparam logic [2:0] ANOM_NO_DRDY = 3'd2;
    localparam logic [2:0] ANOM_FAULT   = 3'd3;
    localparam logic [2:0] ANOM_BREAK   = 3'd4;
    localparam logic [2:0] ANOM_ILLEGAL = 3'd5;

    // Status and reason bit positions
    localparam int STS_BSY  = 7;
    localparam int STS_DRDY = 6;
    localparam int STS_DF   = 5;
    localparam int STS_DRQ  = 3;
    localparam int STS_ERR  = 0;
    localparam int RSN_COD  = 0;
    localparam int RSN_IO   = 1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  status;
        logic [7:0]  reason;
        logic [15:0] byte_count;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  anomaly;
        logic [15:0] buffer_count;
        logic [16:0] dummy_count;
        logic [15:0] buffer_position;
        logic [31:0] total_moved;
    } res_item_t;

endpackage

/* rtl/core/appt_if.sv */
// Valid/ready channel interfaces for command and result beats.
`timescale 1ns / 1ps

interface appt_cmd_if import appt_pkg::*;;
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface appt_res_if import appt_pkg::*;;
    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/atapi_packet_phase_tracker.sv */
// Top level: ATAPI PIO packet phase tracker with registered input and result.
`timescale 1ns / 1ps
//
// Usage:
//   cmd carries one beat per start or interrupt event (kind, status, reason,
//   byte_count). res returns exactly one beat per command beat: the new phase,
//   an anomaly code, the buffer and dummy counts, the buffer position where the
//   move begins and the running byte total.
//   cfg_we/cfg_wdata load the caller buffer size (transfer limit); write it
//   only while no command beat is in flight.
// Timing:
//   A command beat lands in the input register, is decoded and is written to
//   the result register once that register is free. One beat per cycle is
//   sustained while res is not stalled; the limit comes from the single
//   decode/add stage that updates the phase, total and offset.
// Reset:
//   rst_n clears the phase to idle, the total, the offset and the limit, and
//   empties both registers.
// Stall:
//   While res is stalled, one more beat is taken into the input register;
//   cmd.ready drops only when both registers hold beats.
//
module atapi_packet_phase_tracker
    import appt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    appt_cmd_if.sink    cmd,
    appt_res_if.source  res,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    cmd_item_t   cmd_reg;
    logic        cmd_valid_reg;
    res_item_t   res_reg;
    logic        res_valid_reg;
    logic [2:0]  phase_reg;
    logic [31:0] total_reg;
    logic [15:0] offset_reg;
    logic [15:0] limit_reg;

    logic        advance;
    logic [2:0]  phase_next;
    logic [31:0] total_next;
    logic [15:0] offset_next;
    res_item_t   res_next;

    logic        bsy, drdy, df, drq, err, cod, io;
    logic [2:0]  base_phase;
    logic [31:0] base_total;
    logic [15:0] base_offset;
    logic [32:0] d2h_sum;
    logic [15:0] d2h_rest;
    logic [16:0] lim_inc;
    logic [16:0] cnt_inc;
    logic [16:0] pad_inc;

    // Move a beat out of the input register when the result register frees up
    assign advance   = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || advance;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    // Split the status and reason bytes
    assign bsy  = cmd_reg.status[STS_BSY];
    assign drdy = cmd_reg.status[STS_DRDY];
    assign df   = cmd_reg.status[STS_DF];
    assign drq  = cmd_reg.status[STS_DRQ];
    assign err  = cmd_reg.status[STS_ERR];
    assign cod  = cmd_reg.reason[RSN_COD];
    assign io   = cmd_reg.reason[RSN_IO];

    // Start beats see cleared state
    assign base_phase  = (cmd_reg.kind == KIND_START) ? PHASE_IDLE : phase_reg;
    assign base_total  = (cmd_reg.kind == KIND_START) ? 32'd0 : total_reg;
    assign base_offset = (cmd_reg.kind == KIND_START) ? 16'd0 : offset_reg;

    // Shared arithmetic for the data phases
    assign d2h_sum  = {1'b0, total_reg} + {17'd0, cmd_reg.byte_count};
    assign d2h_rest = ({16'd0, limit_reg} > total_reg) ? (limit_reg - total_reg[15:0])
                                                        : 16'd0;
    assign lim_inc  = {1'b0, limit_reg} + 17'd1;
    assign cnt_inc  = {1'b0, cmd_reg.byte_count} + 17'd1;
    assign pad_inc  = {1'b0, cmd_reg.byte_count} - {1'b0, limit_reg} + 17'd1;

    // Decode the event into phase, anomaly and counts
    always_comb
    begin
        phase_next               = base_phase;
        total_next               = base_total;
        offset_next              = base_offset;
        res_next.anomaly         = ANOM_NONE;
        res_next.buffer_count    = 16'd0;
        res_next.dummy_count     = 17'd0;
        res_next.buffer_position = base_offset;

        if (cmd_reg.kind == KIND_START)
        begin
            // state already cleared
        end
        else if (bsy)
        begin
            res_next.anomaly = ANOM_BUSY;
        end
        else if (!drq)
        begin
            if (!io && !cod)
            begin
                phase_next = PHASE_RELEASE;
            end
            else if (io && cod)
            begin
                if (!drdy)
                    res_next.anomaly = ANOM_NO_DRDY;
                else
                    phase_next = PHASE_STATUS;
            end
            else if (!cod && io && drdy && !err)
            begin
                res_next.anomaly = df ? ANOM_FAULT : ANOM_BREAK;
            end
            else
            begin
                res_next.anomaly = ANOM_ILLEGAL;
            end
        end
        else if (cod)
        begin
            if (!io)
            begin
                phase_next = PHASE_COMMAND;
            end
            else
            begin
                phase_next           = PHASE_MESSAGE;
                total_next           = {16'd0, cmd_reg.byte_count};
                res_next.dummy_count = cnt_inc;
            end
        end
        else if (!io)
        begin
            phase_next = PHASE_H2D;
            total_next = {16'd0, cmd_reg.byte_count};
            if (cmd_reg.byte_count > limit_reg)
            begin
                res_next.buffer_count = lim_inc[16:1];
                res_next.dummy_count  = {1'b0, pad_inc[16:1]};
            end
            else
            begin
                res_next.buffer_count = cnt_inc[16:1];
            end
        end
        else
        begin
            phase_next = PHASE_D2H;
            total_next = d2h_sum[31:0];
            if (d2h_sum > {17'd0, limit_reg})
            begin
                res_next.buffer_count = d2h_rest;
                res_next.dummy_count  = {1'b0, cmd_reg.byte_count - d2h_rest};
                offset_next           = offset_reg + d2h_rest;
            end
            else
            begin
                res_next.buffer_count = cmd_reg.byte_count;
                offset_next           = offset_reg + cmd_reg.byte_count;
            end
        end

        res_next.phase       = phase_next;
        res_next.total_moved = total_next;
    end

    // Hold the transfer limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 16'd0;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // Track input and result register occupancy and the phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PHASE_IDLE;
            total_reg     <= 32'd0;
            offset_reg    <= 16'd0;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                total_reg     <= total_next;
                offset_reg    <= offset_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            cmd_reg <= cmd.data;
        if (advance)
            res_reg <= res_next;
    end

`ifndef SYNTH
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (cmd_valid_reg && res_valid_reg && !res.ready))
        else $error("input stalled with a free register");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg.kind == KIND_START) |=>
            (res.data.phase == PHASE_IDLE && res.data.total_moved == 32'd0 &&
             res.data.buffer_position == 16'd0))
        else $error("start beat did not clear the state");

    a_anomaly_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.anomaly != ANOM_NONE) |=>
            (res.data.phase == $past(phase_reg) && res.data.buffer_count == 16'd0 &&
             res.data.dummy_count == 17'd0))
        else $error("anomaly changed the phase or reported counts");

    // Only a clean device-to-host move, not an anomaly that keeps that phase
    a_d2h_split: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg.kind == KIND_IRQ && res_next.anomaly == ANOM_NONE &&
         phase_next == PHASE_D2H) |->
            ({1'b0, res_next.buffer_count} + res_next.dummy_count ==
             {1'b0, cmd_reg.byte_count}))
        else $error("device-to-host split does not add up to the byte count");
`endif

endmodule
